@@ hdl/rrrw_pkg.sv @@
// Shared constants and types of the rolling risk ratio window.
package rrrw_pkg;

  localparam int WINDOW_MAX_DEF = 1024;
  localparam int WLEN_W         = 11;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 11'd20;
  localparam int DATA_W         = 32;
  localparam int OUT_TDATA_W    = 128;

  typedef enum logic [0:0] {
    REG_WINDOW_LENGTH  = 1'b0,
    REG_RISK_FREE_RATE = 1'b1
  } reg_idx_t;

endpackage

@@ hdl/rrrw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module rrrw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/rolling_risk_ratio_window.sv @@
// Rolling mean, volatility, Sharpe and Sortino ratio over a sliding window of returns.
//
// Input transactions carry one Q8.24 return in in_tdata and a start-of-series flag in
// in_tuser that empties the window before the sample is taken. The returns sit in a ring
// RAM; running sum, sum of squares, downside sum of squares and downside count are updated
// on entry and eviction. Once the window holds window_length samples, each input yields
// one output transaction with mean, volatility, Sharpe and Sortino ratio.
// No new input is accepted until the current item is through. An item that gives a result
// uses the shared one-bit-per-cycle divider (five divisions) and the two-bits-per-cycle
// square root unit; the eviction pass is skipped while nothing is evicted, and a ratio
// that is zero needs no division.
// A finished result waits in the output register; the next input is accepted while it
// waits, and the block stalls only when a second result is ready before the first is taken.
// Reset (synchronous, active low) empties the window, restores window_length to 20 and
// risk_free_rate to 0. Any configuration write also empties the window and must only be
// issued while the block is idle.
module rolling_risk_ratio_window import rrrw_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [31:0]            in_tdata,   // sample_return[31:0]
  input  logic                   in_tuser,   // start_of_series
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // rolling_mean[31:0], rolling_volatility[62:32], sharpe_ratio[94:63],
  // sortino_ratio[126:95], zero[127]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,  // ratio_saturated
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [DATA_W-1:0]      cfg_wdata
);

  localparam int AW   = $clog2(WINDOW_MAX);
  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int SW   = 32 + AW;
  localparam int SQW  = 47 + AW;
  localparam int DSQW = 48 + AW;
  localparam int DVW  = DSQW;
  localparam int IW   = $clog2(DVW + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_SQ, S_DSQ, S_UPD,
    S_MEAN_DIV, S_MEAN_END, S_MSQ_DIV, S_MSQ_END, S_VAR,
    S_VOL_SQRT, S_VOL_END, S_SHARPE_DIV, S_SHARPE_END,
    S_DS_START, S_DS_DIV, S_DS_END, S_DD_SQRT, S_DD_END,
    S_SORT_DIV, S_SORT_END, S_DONE
  } state_t;

  state_t state_r;

  logic [WLEN_W-1:0] wlen_r;
  logic [31:0]       rf_r;
  logic [AW-1:0]     slot_r;
  logic [CW-1:0]     fill_r;
  logic [CW-1:0]     n_r;
  logic              evict_r;
  logic [SW-1:0]     sum_r;
  logic [SQW-1:0]    sqsum_r;
  logic [DSQW-1:0]   dsum_r;
  logic [CW-1:0]     dcount_r;
  logic [31:0]       x_r;
  logic [31:0]       cur_r;
  logic              adding_r;
  logic [63:0]       prod_r;
  logic [31:0]       mean_r;
  logic [32:0]       exc_r;
  logic [SQW-1:0]    msq_r;
  logic [30:0]       vol_r;
  logic [31:0]       sharpe_r;
  logic [31:0]       sortino_r;
  logic              sat_r;

  // Shared divider and square root registers.
  logic [DVW-1:0]    dvd_r;
  logic [31:0]       dvs_r;
  logic [31:0]       drem_r;
  logic [63:0]       sqin_r;
  logic [33:0]       srem_r;
  logic [31:0]       root_r;
  logic [IW-1:0]     cnt_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_sat_r;

  logic [31:0]       rd_data;
  logic              ram_we;

  // Effective window length, clamped to 2..WINDOW_MAX.
  logic [CW-1:0] n_eff;
  always_comb begin
    if (wlen_r < WLEN_W'(2)) begin
      n_eff = CW'(2);
    end else if (32'(wlen_r) > WINDOW_MAX) begin
      n_eff = CW'(WINDOW_MAX);
    end else begin
      n_eff = CW'(wlen_r);
    end
  end

  logic [AW-1:0] slot_base, slot_eff;
  logic [CW-1:0] fill_base;
  assign slot_base = in_tuser ? '0 : slot_r;
  assign slot_eff  = (CW'(slot_base) >= n_eff) ? '0 : slot_base;
  assign fill_base = in_tuser ? '0 : fill_r;

  logic accept;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign ram_we = (state_r == S_READ);

  rrrw_ram #(
    .WIDTH (32),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (x_r),
    .raddr (slot_eff),
    .rdata (rd_data)
  );

  // Sample terms.
  logic [32:0] cdiff, cneg;
  logic [31:0] cur_mag, cdiff_mag, mean_mag;
  logic        cur_below;
  assign cdiff     = {cur_r[31], cur_r} - {rf_r[31], rf_r};
  assign cneg      = 33'd0 - cdiff;
  assign cdiff_mag = cneg[31:0];
  assign cur_below = $signed(cur_r) < $signed(rf_r);
  assign cur_mag   = cur_r[31] ? (32'd0 - cur_r) : cur_r;
  assign mean_mag  = mean_r[31] ? (32'd0 - mean_r) : mean_r;

  logic [31:0] mul_a;
  logic [63:0] prod_nxt;
  always_comb begin
    unique case (state_r)
      S_SQ:    mul_a = cur_mag;
      S_DSQ:   mul_a = cdiff_mag;
      default: mul_a = mean_mag;
    endcase
  end
  assign prod_nxt = 64'(mul_a) * 64'(mul_a);

  logic [SW-1:0]   cur_ext;
  logic [SQW-1:0]  sq_term;
  logic [DSQW-1:0] dsq_term;
  assign cur_ext  = SW'($signed(cur_r));
  assign sq_term  = SQW'(prod_r[63:16]);
  assign dsq_term = DSQW'(prod_r[63:16]);

  // Restoring divider step: one quotient bit per cycle.
  logic [32:0]    drem_sh, drem_diff;
  logic           dge;
  logic [31:0]    drem_nxt;
  logic [DVW-1:0] dvd_nxt;
  assign drem_sh   = {drem_r, dvd_r[DVW-1]};
  assign drem_diff = drem_sh - {1'b0, dvs_r};
  assign dge       = drem_sh >= {1'b0, dvs_r};
  assign drem_nxt  = dge ? drem_diff[31:0] : drem_sh[31:0];
  assign dvd_nxt   = {dvd_r[DVW-2:0], dge};

  // Square root step: two radicand bits per cycle.
  logic [35:0] srem_sh, strial, srem_diff;
  logic        sge;
  logic [33:0] srem_nxt;
  logic [31:0] root_nxt;
  assign srem_sh   = {srem_r, sqin_r[63:62]};
  assign strial    = {2'b00, root_r, 2'b01};
  assign sge       = srem_sh >= strial;
  assign srem_diff = srem_sh - strial;
  assign srem_nxt  = sge ? srem_diff[33:0] : srem_sh[33:0];
  assign root_nxt  = {root_r[30:0], sge};

  logic div_busy, sqrt_busy, unit_last;
  assign div_busy  = (state_r == S_MEAN_DIV) || (state_r == S_MSQ_DIV) ||
                     (state_r == S_SHARPE_DIV) || (state_r == S_DS_DIV) ||
                     (state_r == S_SORT_DIV);
  assign sqrt_busy = (state_r == S_VOL_SQRT) || (state_r == S_DD_SQRT);
  assign unit_last = (cnt_r == IW'(1));

  // Ratio saturation from the quotient magnitude and the sign of the excess return.
  logic        exc_neg, exc_zero;
  logic [32:0] exc_mag;
  logic        q_hi_pos, q_hi_neg, ratio_sat;
  logic [31:0] ratio_val, dev0_val;
  assign exc_neg   = exc_r[32];
  assign exc_zero  = (exc_r == 33'd0);
  assign exc_mag   = exc_neg ? (33'd0 - exc_r) : exc_r;
  assign q_hi_pos  = |dvd_r[DVW-1:31];
  assign q_hi_neg  = (|dvd_r[DVW-1:32]) || (dvd_r[31] && (|dvd_r[30:0]));
  assign ratio_sat = exc_neg ? q_hi_neg : q_hi_pos;
  assign ratio_val = ratio_sat ? (exc_neg ? 32'h8000_0000 : 32'h7FFF_FFFF)
                               : (exc_neg ? (32'd0 - dvd_r[31:0]) : dvd_r[31:0]);
  assign dev0_val  = exc_zero ? 32'd0 : (exc_neg ? 32'h8000_0000 : 32'h7FFF_FFFF);

  logic [SW-1:0] sum_mag;
  assign sum_mag = sum_r[SW-1] ? (SW'(0) - sum_r) : sum_r;

  logic [CW-1:0] fill_nxt;
  logic          slot_wrap;
  assign fill_nxt  = evict_r ? n_r : fill_r + CW'(1);
  assign slot_wrap = (CW'(slot_r) + CW'(1)) >= n_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (div_busy) begin
      dvd_r  <= dvd_nxt;
      drem_r <= drem_nxt;
      cnt_r  <= cnt_r - IW'(1);
    end
    if (sqrt_busy) begin
      sqin_r <= {sqin_r[61:0], 2'b00};
      srem_r <= srem_nxt;
      root_r <= root_nxt;
      cnt_r  <= cnt_r - IW'(1);
    end
    if (out_valid_r && out_tready) begin
      out_valid_r <= 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          x_r     <= in_tdata;
          n_r     <= n_eff;
          slot_r  <= slot_eff;
          fill_r  <= fill_base;
          evict_r <= fill_base >= n_eff;
          if (in_tuser) begin
            sum_r    <= '0;
            sqsum_r  <= '0;
            dsum_r   <= '0;
            dcount_r <= '0;
          end
          state_r <= S_READ;
        end
      end
      S_READ: begin
        // The evicted sample is accounted first, then the new one.
        cur_r    <= evict_r ? rd_data : x_r;
        adding_r <= !evict_r;
        state_r  <= S_SQ;
      end
      S_SQ: begin
        state_r <= S_DSQ;
      end
      S_DSQ: begin
        sum_r   <= adding_r ? sum_r + cur_ext : sum_r - cur_ext;
        sqsum_r <= adding_r ? sqsum_r + sq_term : sqsum_r - sq_term;
        state_r <= S_UPD;
      end
      S_UPD: begin
        if (cur_below) begin
          dsum_r   <= adding_r ? dsum_r + dsq_term : dsum_r - dsq_term;
          dcount_r <= adding_r ? dcount_r + CW'(1) : dcount_r - CW'(1);
        end
        if (!adding_r) begin
          cur_r    <= x_r;
          adding_r <= 1'b1;
          state_r  <= S_SQ;
        end else begin
          slot_r <= slot_wrap ? '0 : slot_r + AW'(1);
          fill_r <= fill_nxt;
          if (fill_nxt < n_r) begin
            state_r <= S_IDLE;
          end else begin
            dvd_r   <= DVW'(sum_mag);
            dvs_r   <= 32'(n_r);
            drem_r  <= '0;
            cnt_r   <= IW'(DVW);
            state_r <= S_MEAN_DIV;
          end
        end
      end
      S_MEAN_DIV: begin
        if (unit_last) state_r <= S_MEAN_END;
      end
      S_MEAN_END: begin
        mean_r  <= sum_r[SW-1] ? (32'd0 - dvd_r[31:0]) : dvd_r[31:0];
        dvd_r   <= DVW'(sqsum_r);
        dvs_r   <= 32'(n_r);
        drem_r  <= '0;
        cnt_r   <= IW'(DVW);
        state_r <= S_MSQ_DIV;
      end
      S_MSQ_DIV: begin
        if (unit_last) state_r <= S_MSQ_END;
      end
      S_MSQ_END: begin
        msq_r   <= dvd_r[SQW-1:0];
        exc_r   <= {mean_r[31], mean_r} - {rf_r[31], rf_r};
        state_r <= S_VAR;
      end
      S_VAR: begin
        // The mean square never exceeds 2^46, so its low 47 bits carry it whole.
        if (msq_r > SQW'(prod_r[63:16])) begin
          sqin_r <= {1'b0, msq_r[46:0] - prod_r[62:16], 16'd0};
        end else begin
          sqin_r <= '0;
        end
        srem_r  <= '0;
        root_r  <= '0;
        cnt_r   <= IW'(32);
        sat_r   <= 1'b0;
        state_r <= S_VOL_SQRT;
      end
      S_VOL_SQRT: begin
        if (unit_last) state_r <= S_VOL_END;
      end
      S_VOL_END: begin
        vol_r <= root_r[30:0];
        if (root_r == 32'd0) begin
          sharpe_r <= '0;
          state_r  <= S_DS_START;
        end else begin
          dvd_r   <= DVW'({exc_mag, 16'd0});
          dvs_r   <= root_r;
          drem_r  <= '0;
          cnt_r   <= IW'(DVW);
          state_r <= S_SHARPE_DIV;
        end
      end
      S_SHARPE_DIV: begin
        if (unit_last) state_r <= S_SHARPE_END;
      end
      S_SHARPE_END: begin
        sharpe_r <= ratio_val;
        sat_r    <= ratio_sat;
        state_r  <= S_DS_START;
      end
      S_DS_START: begin
        if (dcount_r == '0) begin
          sortino_r <= '0;
          state_r   <= S_DONE;
        end else begin
          dvd_r   <= DVW'(dsum_r);
          dvs_r   <= 32'(dcount_r);
          drem_r  <= '0;
          cnt_r   <= IW'(DVW);
          state_r <= S_DS_DIV;
        end
      end
      S_DS_DIV: begin
        if (unit_last) state_r <= S_DS_END;
      end
      S_DS_END: begin
        sqin_r  <= {dvd_r[47:0], 16'd0};
        srem_r  <= '0;
        root_r  <= '0;
        cnt_r   <= IW'(32);
        state_r <= S_DD_SQRT;
      end
      S_DD_SQRT: begin
        if (unit_last) state_r <= S_DD_END;
      end
      S_DD_END: begin
        if (root_r == 32'd0) begin
          // Downside deviation below resolution: saturate by the sign of the excess.
          sortino_r <= dev0_val;
          sat_r     <= sat_r || !exc_zero;
          state_r   <= S_DONE;
        end else begin
          dvd_r   <= DVW'({exc_mag, 16'd0});
          dvs_r   <= root_r;
          drem_r  <= '0;
          cnt_r   <= IW'(DVW);
          state_r <= S_SORT_DIV;
        end
      end
      S_SORT_DIV: begin
        if (unit_last) state_r <= S_SORT_END;
      end
      S_SORT_END: begin
        sortino_r <= ratio_val;
        sat_r     <= sat_r || ratio_sat;
        state_r   <= S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_r  <= {1'b0, sortino_r, sharpe_r, vol_r, mean_r};
          out_sat_r   <= sat_r;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
      end
      default: state_r <= S_IDLE;
    endcase

    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WINDOW_LENGTH:  wlen_r <= cfg_wdata[WLEN_W-1:0];
        REG_RISK_FREE_RATE: rf_r   <= cfg_wdata;
        default:            wlen_r <= wlen_r;
      endcase
      slot_r   <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
      sqsum_r  <= '0;
      dsum_r   <= '0;
      dcount_r <= '0;
    end

    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wlen_r      <= WLEN_RESET;
      rf_r        <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sqsum_r     <= '0;
      dsum_r      <= '0;
      dcount_r    <= '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

@@ hdl/rrrw_checker.sv @@
// Port-level checks of the rolling risk ratio window and their bind.
module rrrw_checker import rrrw_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transaction");

  a_flat_sharpe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[62:32] == 31'd0 |-> out_tdata[94:63] == 32'd0)
    else $error("nonzero Sharpe ratio at zero volatility");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[94:63] == 32'h7FFF_FFFF || out_tdata[94:63] == 32'h8000_0000 ||
      out_tdata[126:95] == 32'h7FFF_FFFF || out_tdata[126:95] == 32'h8000_0000)
    else $error("saturation flag without a clipped ratio");

endmodule

bind rolling_risk_ratio_window rrrw_checker u_rrrw_checker (.*);
